>>> sv/lzwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZSS window decompressor: status codes,
// register indexes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam logic [7:0]  FILL_BYTE       = 8'h20;
	localparam logic [11:0] WPOS_RESET      = 12'hFEE;
	localparam logic [31:0] OUT_LIMIT_RESET = 32'hFFFF_FFFF;
	localparam logic [1:0]  MIN_MATCH_RESET = 2'd2;

	localparam logic REG_OUT_LIMIT = 1'b0;
	localparam logic REG_MIN_MATCH = 1'b1;

	localparam logic [2:0] ST_RUNNING  = 3'd0;
	localparam logic [2:0] ST_CLEAN    = 3'd1;
	localparam logic [2:0] ST_IN_GROUP = 3'd2;
	localparam logic [2:0] ST_IN_PAIR  = 3'd3;
	localparam logic [2:0] ST_LIMIT    = 3'd4;

	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_LIT,
		SEL_WIN
	} out_sel_t;

	typedef enum logic [1:0] {
		FK_NORMAL,
		FK_LIMIT,
		FK_HALTED
	} fin_kind_t;

	typedef struct packed {
		logic      clear_wr;
		logic      take_in;
		logic      load_flags;
		logic      shift_flags;
		logic      set_pair;
		logic      start_match;
		logic      read_win;
		logic      load_out;
		out_sel_t  out_sel;
		logic      out_last;
		fin_kind_t fin_kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic halted;
		logic flag_expect;
		logic flag_bit;
		logic pair_pending;
		logic len_zero;
		logic can_emit;
		logic can_emit_next;
		logic remain_one;
		logic slot_free;
	} ctrl_sts_t;

endpackage
`default_nettype wire

>>> sv/lzss_window_decompressor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_window_decompressor
// LZSS decoder, 4096-byte ring window: one compressed byte per input beat,
// at most one decoded byte per result beat, with end and output limit status.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   in_byte, end_of_input
//   result   out_valid / out_ready data_byte, data_valid, last, status,
//                                  total_count
//   config   APB psel / penable    paddr, pwrite, pwdata, prdata, pready
//
// A flag byte, a pair's first byte, a literal or a match that copies nothing
// passes the idle, decode and finish or literal emit states; a match that
// copies bytes passes idle and decode, then for each byte, up to 18, a
// registered read of the window RAM followed by the write of that byte.
// After reset a clearing pass fills the window with FILL_BYTE, during which
// no input beat is taken; configuration writes are taken at any time.
// A stalled result beat holds the decoder until the output register frees.
// ----------------------------------------------------------------------------
module lzss_window_decompressor
	import lzwd_pkg::*;
#(
	parameter int WINDOW_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        last,
	output logic [2:0]  status,
	output logic [31:0] total_count
);

	logic [31:0] out_limit_q;
	logic [1:0]  min_match_q;
	logic        reg_idx;
	logic        cfg_write;
	ctrl_cmd_t   cmd;
	ctrl_sts_t   sts;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= OUT_LIMIT_RESET;
			min_match_q <= MIN_MATCH_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_OUT_LIMIT: out_limit_q <= pwdata;
				REG_MIN_MATCH: min_match_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OUT_LIMIT: prdata = out_limit_q;
			REG_MIN_MATCH: prdata = {30'd0, min_match_q};
			default:       prdata = 32'd0;
		endcase
	end

	lzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzwd_datapath #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.out_limit    (out_limit_q),
		.min_match    (min_match_q),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.last         (last),
		.status       (status),
		.total_count  (total_count)
	);

endmodule
`default_nettype wire

>>> sv/lzwd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/lzwd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Controller of the decompressor: sequences the window clearing pass, token
// decoding, match copying and the delivery of result beats.
// ----------------------------------------------------------------------------
module lzwd_ctrl
	import lzwd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_FIN,
		S_EMIT_LIT,
		S_RD,
		S_EMIT_WIN
	} state_t;

	state_t    state_q;
	state_t    state_d;
	fin_kind_t kind_q;
	fin_kind_t kind_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		kind_d  = kind_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FIN;
				kind_d  = FK_NORMAL;
				if (sts.halted) begin
					kind_d = FK_HALTED;
				end else if (sts.flag_expect) begin
					cmd.load_flags = 1'b1;
				end else if (sts.flag_bit) begin
					cmd.shift_flags = 1'b1;
					if (sts.can_emit) begin
						state_d = S_EMIT_LIT;
					end else begin
						kind_d = FK_LIMIT;
					end
				end else if (!sts.pair_pending) begin
					cmd.set_pair = 1'b1;
				end else begin
					cmd.start_match = 1'b1;
					cmd.shift_flags = 1'b1;
					if (sts.len_zero) begin
						kind_d = FK_NORMAL;
					end else if (!sts.can_emit) begin
						kind_d = FK_LIMIT;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_FIN: begin
				cmd.out_sel  = SEL_NONE;
				cmd.out_last = 1'b1;
				cmd.fin_kind = kind_q;
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_EMIT_LIT: begin
				cmd.out_sel  = SEL_LIT;
				cmd.out_last = 1'b1;
				cmd.fin_kind = FK_NORMAL;
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_RD: begin
				cmd.read_win = 1'b1;
				state_d      = S_EMIT_WIN;
			end
			S_EMIT_WIN: begin
				cmd.out_sel  = SEL_WIN;
				cmd.out_last = sts.remain_one || !sts.can_emit_next;
				cmd.fin_kind = sts.remain_one ? FK_NORMAL : FK_LIMIT;
				if (sts.slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = cmd.out_last ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q  <= FK_NORMAL;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	property p_read_then_emit;
		@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |=> (state_q == S_EMIT_WIN);
	endproperty
	a_read_then_emit: assert property (p_read_then_emit)
		else $error("Window read was not followed by its emit state.");

	property p_no_take_while_busy;
		@(posedge clk) disable iff (!arst_n)
		cmd.take_in |=> (state_q == S_DECODE);
	endproperty
	a_no_take_while_busy: assert property (p_no_take_while_busy)
		else $error("An accepted input beat was not decoded next.");

endmodule
`default_nettype wire

>>> sv/lzwd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_datapath
// Datapath of the decompressor: the ring window, token state, match address
// and length counters, byte count and the result output register.
// ----------------------------------------------------------------------------
module lzwd_datapath
	import lzwd_pkg::*;
#(
	parameter int WINDOW_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	output ctrl_sts_t   sts,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	input  logic [31:0] out_limit,
	input  logic [1:0]  min_match,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        last,
	output logic [2:0]  status,
	output logic [31:0] total_count
);

	localparam int WIN_DEPTH = 1 << WINDOW_BITS;

	logic [7:0]             byte_q;
	logic                   eoi_q;
	logic [8:0]             flag_shift_q;
	logic [7:0]             pair_low_q;
	logic                   pair_pending_q;
	logic [WINDOW_BITS-1:0] wpos_q;
	logic [WINDOW_BITS-1:0] rpos_q;
	logic [4:0]             remain_q;
	logic [31:0]            count_q;
	logic                   halted_q;
	logic [WINDOW_BITS-1:0] clr_addr_q;

	logic                   out_valid_q;
	logic [7:0]             data_byte_q;
	logic                   data_valid_q;
	logic                   last_q;
	logic [2:0]             status_q;
	logic [31:0]            total_q;

	logic [4:0]             match_len;
	logic                   emitting;
	logic                   set_halt;
	logic [31:0]            count_inc;
	logic [2:0]             fin_status;
	logic [7:0]             emit_byte;
	logic [7:0]             win_rdata;
	logic                   win_we;
	logic [WINDOW_BITS-1:0] win_waddr;
	logic [7:0]             win_wdata;

	assign match_len = {1'b0, byte_q[3:0]} + {3'b000, min_match};
	assign emitting  = cmd.load_out && (cmd.out_sel != SEL_NONE);
	assign count_inc = count_q + 32'd1;
	assign set_halt  = cmd.load_out && cmd.out_last &&
	                   ((cmd.fin_kind == FK_LIMIT) || ((cmd.fin_kind == FK_NORMAL) && eoi_q));
	assign emit_byte = (cmd.out_sel == SEL_LIT) ? byte_q : win_rdata;

	always_comb begin
		case (cmd.fin_kind)
			FK_NORMAL: begin
				if (!eoi_q) begin
					fin_status = ST_RUNNING;
				end else if (pair_pending_q) begin
					fin_status = ST_IN_PAIR;
				end else if (flag_shift_q > 9'd1) begin
					fin_status = ST_IN_GROUP;
				end else begin
					fin_status = ST_CLEAN;
				end
			end
			FK_LIMIT: fin_status = ST_LIMIT;
			default:  fin_status = sts.can_emit ? ST_CLEAN : ST_LIMIT;
		endcase
	end

	always_comb begin
		sts.clear_done    = &clr_addr_q;
		sts.halted        = halted_q;
		sts.flag_expect   = (flag_shift_q <= 9'd1);
		sts.flag_bit      = flag_shift_q[0];
		sts.pair_pending  = pair_pending_q;
		sts.len_zero      = (match_len == 5'd0);
		sts.can_emit      = (count_q < out_limit);
		sts.can_emit_next = ({1'b0, count_q} + 33'd1) < {1'b0, out_limit};
		sts.remain_one    = (remain_q == 5'd1);
		sts.slot_free     = !out_valid_q || out_ready;
	end

	assign win_we    = cmd.clear_wr || emitting;
	assign win_waddr = cmd.clear_wr ? clr_addr_q : wpos_q;
	assign win_wdata = cmd.clear_wr ? FILL_BYTE : emit_byte;

	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (WIN_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (win_we),
		.waddr (win_waddr),
		.wdata (win_wdata),
		.re    (cmd.read_win),
		.raddr (rpos_q),
		.rdata (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_shift_q   <= '0;
			pair_pending_q <= 1'b0;
			wpos_q         <= WINDOW_BITS'(WPOS_RESET);
			count_q        <= '0;
			halted_q       <= 1'b0;
			clr_addr_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.clear_wr) begin
				clr_addr_q <= clr_addr_q + WINDOW_BITS'(1);
			end
			if (cmd.load_flags) begin
				flag_shift_q <= {1'b1, byte_q};
			end else if (cmd.shift_flags) begin
				flag_shift_q <= {1'b0, flag_shift_q[8:1]};
			end
			if (cmd.set_pair) begin
				pair_pending_q <= 1'b1;
			end else if (cmd.start_match) begin
				pair_pending_q <= 1'b0;
			end
			if (emitting) begin
				wpos_q  <= wpos_q + WINDOW_BITS'(1);
				count_q <= count_inc;
			end
			if (set_halt) begin
				halted_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			byte_q <= in_byte;
			eoi_q  <= end_of_input;
		end
		if (cmd.set_pair) begin
			pair_low_q <= byte_q;
		end
		if (cmd.start_match) begin
			rpos_q   <= WINDOW_BITS'({byte_q[7:4], pair_low_q});
			remain_q <= match_len;
		end else if (cmd.read_win) begin
			rpos_q <= rpos_q + WINDOW_BITS'(1);
		end
		if (emitting) begin
			remain_q <= remain_q - 5'd1;
		end
		if (cmd.load_out) begin
			data_byte_q  <= emitting ? emit_byte : 8'd0;
			data_valid_q <= emitting;
			last_q       <= cmd.out_last;
			status_q     <= cmd.out_last ? fin_status : ST_RUNNING;
			total_q      <= cmd.out_last ? (emitting ? count_inc : count_q) : 32'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = data_byte_q;
	assign data_valid  = data_valid_q;
	assign last        = last_q;
	assign status      = status_q;
	assign total_count = total_q;

	property p_load_into_free_slot;
		@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.slot_free;
	endproperty
	a_load_into_free_slot: assert property (p_load_into_free_slot)
		else $error("Result beat loaded while the previous one was still waiting.");

	property p_no_emit_when_halted;
		@(posedge clk) disable iff (!arst_n)
		halted_q |-> !emitting;
	endproperty
	a_no_emit_when_halted: assert property (p_no_emit_when_halted)
		else $error("A byte was decoded after the block halted.");

	property p_count_follows_emit;
		@(posedge clk) disable iff (!arst_n)
		emitting |=> (count_q == $past(count_q) + 32'd1);
	endproperty
	a_count_follows_emit: assert property (p_count_follows_emit)
		else $error("Byte count did not advance with a decoded byte.");

endmodule
`default_nettype wire
